### design/stack_machine_core_macros.svh
// assertion macros for the stack machine core
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef STACK_MACHINE_CORE_MACROS_SVH
`define STACK_MACHINE_CORE_MACROS_SVH

// same-cycle implication
`define SMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/smc_pkg.sv
// shared constants, codes and types of the stack machine core
// no dependencies
package smc_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int STACK_DEPTH = 64;
  localparam int WORD_BYTES  = 8;
  localparam int WORD_W      = 64;

  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam int IP_W   = $clog2(MEM_BYTES + 1);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int BC_W   = $clog2(WORD_BYTES + 1);
  localparam int MDU_CW = $clog2(WORD_W);

  // result status codes
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_EXIT    = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_DIVZ    = 3'd4;
  localparam logic [2:0] ST_BADOP   = 3'd5;
  localparam logic [2:0] ST_BADADDR = 3'd6;

  // operation numbers
  localparam logic [5:0] OP_LOAD     = 6'd0;
  localparam logic [5:0] OP_STORE    = 6'd1;
  localparam logic [5:0] OP_LOADBYTE = 6'd2;
  localparam logic [5:0] OP_STOREBYTE = 6'd3;
  localparam logic [5:0] OP_EXIT     = 6'd4;
  localparam logic [5:0] OP_ADD      = 6'd5;
  localparam logic [5:0] OP_SUB      = 6'd6;
  localparam logic [5:0] OP_MUL      = 6'd7;
  localparam logic [5:0] OP_DIV      = 6'd8;
  localparam logic [5:0] OP_MOD      = 6'd9;
  localparam logic [5:0] OP_NEGATE   = 6'd10;
  localparam logic [5:0] OP_DUP      = 6'd11;
  localparam logic [5:0] OP_SWAP     = 6'd12;
  localparam logic [5:0] OP_POP      = 6'd13;
  localparam logic [5:0] OP_BAND     = 6'd14;
  localparam logic [5:0] OP_BOR      = 6'd15;
  localparam logic [5:0] OP_BNOT     = 6'd16;
  localparam logic [5:0] OP_XOR      = 6'd17;
  localparam logic [5:0] OP_SHR      = 6'd18;
  localparam logic [5:0] OP_SHL      = 6'd19;
  localparam logic [5:0] OP_SAR      = 6'd20;
  localparam logic [5:0] OP_SAL      = 6'd21;
  localparam logic [5:0] OP_AND      = 6'd22;
  localparam logic [5:0] OP_OR       = 6'd23;
  localparam logic [5:0] OP_NOT      = 6'd24;
  localparam logic [5:0] OP_EQ       = 6'd25;
  localparam logic [5:0] OP_NE       = 6'd26;
  localparam logic [5:0] OP_GT       = 6'd27;
  localparam logic [5:0] OP_LT       = 6'd28;
  localparam logic [5:0] OP_GTE      = 6'd29;
  localparam logic [5:0] OP_LTE      = 6'd30;
  localparam logic [5:0] OP_JMP      = 6'd31;
  localparam logic [5:0] OP_JMPZ     = 6'd32;

  typedef enum logic [1:0] {
    MDU_MUL,
    MDU_DIV,
    MDU_REM
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_req_t;

endpackage

### design/smc_if.sv
// item channels of the stack machine core: request and response
// depends on smc_pkg
interface smc_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [11:0]               load_addr;
  logic [7:0]                load_byte;

  modport source (output valid, req_type, load_addr, load_byte, input ready);
  modport sink   (input valid, req_type, load_addr, load_byte, output ready);
endinterface

interface smc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [11:0]               next_ip;
  logic signed [63:0]        top_value;
  logic [smc_pkg::SP_W-1:0]  stack_count;
  logic signed [63:0]        exit_code;

  modport source (output valid, status, next_ip, top_value, stack_count, exit_code,
                  input ready);
  modport sink   (input valid, status, next_ip, top_value, stack_count, exit_code,
                  output ready);
endinterface

### design/smc_mdu.sv
// iterative multiply / divide unit, one bit per cycle
// depends on smc_pkg
module smc_mdu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  smc_pkg::mdu_req_t           req_i,
  input  logic [smc_pkg::WORD_W-1:0]  a_i,
  input  logic [smc_pkg::WORD_W-1:0]  b_i,
  output logic                        done_o,
  output logic [smc_pkg::WORD_W-1:0]  res_o
);

  localparam int W = smc_pkg::WORD_W;

  logic                      busy_q, done_q, negq_q, negr_q;
  smc_pkg::mdu_op_e          op_q;
  logic [smc_pkg::MDU_CW-1:0] cnt_q;
  logic [W-1:0]              x_q, y_q, acc_q;
  logic [W-1:0]              a_mag, b_mag;
  logic [W:0]                trial;

  assign a_mag = a_i[W-1] ? (W'(0) - a_i) : a_i;
  assign b_mag = b_i[W-1] ? (W'(0) - b_i) : b_i;
  // restoring divide step: shifted remainder minus divisor
  assign trial = {acc_q, x_q[W-1]} - {1'b0, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= smc_pkg::MDU_MUL;
      cnt_q  <= '0;
      negq_q <= 1'b0;
      negr_q <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      acc_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      op_q   <= req_i.op;
      cnt_q  <= '0;
      acc_q  <= '0;
      negq_q <= a_i[W-1] ^ b_i[W-1];
      negr_q <= a_i[W-1];
      if (req_i.op == smc_pkg::MDU_MUL) begin
        x_q <= a_i;
        y_q <= b_i;
      end else begin
        x_q <= a_mag;
        y_q <= b_mag;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (&cnt_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
      if (op_q == smc_pkg::MDU_MUL) begin
        if (y_q[0]) begin
          acc_q <= acc_q + x_q;
        end
        x_q <= {x_q[W-2:0], 1'b0};
        y_q <= {1'b0, y_q[W-1:1]};
      end else begin
        if (!trial[W]) begin
          acc_q <= trial[W-1:0];
        end else begin
          acc_q <= {acc_q[W-2:0], x_q[W-1]};
        end
        x_q <= {x_q[W-2:0], ~trial[W]};
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_comb begin
    unique case (op_q)
      smc_pkg::MDU_DIV: res_o = negq_q ? (W'(0) - x_q) : x_q;
      smc_pkg::MDU_REM: res_o = negr_q ? (W'(0) - acc_q) : acc_q;
      default:          res_o = acc_q;
    endcase
  end

  assign done_o = done_q;

endmodule

### design/stack_machine_core.sv
// stack machine core: one item at a time; a load item writes its byte and goes to its result,
// a step item passes fetch of 8 bytes from the byte memory, decode, two operand reads,
// one execute, top-of-stack readback and result.
// mul, div and mod also wait in the bit-serial unit; word load and store add a byte loop.
// reset is asynchronous and clears ip, stack count, status and the stopped flag;
// byte memory and operand stack are not cleared.
`include "stack_machine_core_macros.svh"

module stack_machine_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  smc_req_if.sink   req_i,
  smc_rsp_if.source rsp_o
);

  localparam int W = smc_pkg::WORD_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_RD2   = 4'd4;
  localparam logic [3:0] S_EXEC  = 4'd5;
  localparam logic [3:0] S_MEMRD = 4'd6;
  localparam logic [3:0] S_MEMWR = 4'd7;
  localparam logic [3:0] S_MDU   = 4'd8;
  localparam logic [3:0] S_SWAP2 = 4'd9;
  localparam logic [3:0] S_TOP0  = 4'd10;
  localparam logic [3:0] S_TOP1  = 4'd11;
  localparam logic [3:0] S_RESP  = 4'd12;

  logic [3:0]                    state_q, state_d;
  logic [smc_pkg::IP_W-1:0]      ip_q, ip_d;
  logic [smc_pkg::SP_W-1:0]      sp_q, sp_d, sp_m1, sp_m2;
  logic                          stopped_q, stopped_d;
  logic [2:0]                    status_q, status_d, err;
  logic [W-1:0]                  exit_q, exit_d, top_q, top_d, sh_q, sh_d;
  logic [W-1:0]                  v1_q, v1_d, v2_q, v2_d, alu_r;
  logic [5:0]                    op_q, op_d;
  logic                          badop_q, badop_d, bytemode_q, bytemode_d;
  logic [smc_pkg::MEM_AW-1:0]    addr_q, addr_d;
  logic [smc_pkg::BC_W-1:0]      cnt_q, cnt_d;
  logic                          v1_word_ok, v2_word_ok, v1_byte_ok, v2_byte_ok;

  logic [7:0]                    mem_q [smc_pkg::MEM_BYTES];
  logic                          mem_we;
  logic [smc_pkg::MEM_AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]                    mem_wdata, mem_rdata_q;

  logic [W-1:0]                  stk_q [smc_pkg::STACK_DEPTH];
  logic                          stk_we;
  logic [smc_pkg::STK_AW-1:0]    stk_waddr, stk_raddr;
  logic [W-1:0]                  stk_wdata, stk_rdata_q;

  smc_pkg::mdu_req_t             mdu_req;
  logic                          mdu_done;
  logic [W-1:0]                  mdu_res;

  smc_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .a_i    (v1_q),
    .b_i    (v2_q),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_q[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_q[stk_raddr];
  end

  assign sp_m1 = sp_q - 1'b1;
  assign sp_m2 = sp_q - 2'd2;

  assign v1_word_ok = v1_q <= W'(smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES);
  assign v2_word_ok = v2_q <= W'(smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES);
  assign v1_byte_ok = v1_q < W'(smc_pkg::MEM_BYTES);
  assign v2_byte_ok = v2_q < W'(smc_pkg::MEM_BYTES);

  // combinational operations, v1 is the top
  always_comb begin
    case (op_q) inside
      smc_pkg::OP_ADD:    alu_r = v1_q + v2_q;
      smc_pkg::OP_SUB:    alu_r = v1_q - v2_q;
      smc_pkg::OP_NEGATE: alu_r = W'(0) - v1_q;
      smc_pkg::OP_BAND:   alu_r = v1_q & v2_q;
      smc_pkg::OP_BOR:    alu_r = v1_q | v2_q;
      smc_pkg::OP_BNOT:   alu_r = ~v1_q;
      smc_pkg::OP_XOR:    alu_r = v1_q ^ v2_q;
      smc_pkg::OP_SHR:    alu_r = v1_q >> v2_q[5:0];
      smc_pkg::OP_SHL, smc_pkg::OP_SAL: alu_r = v1_q << v2_q[5:0];
      smc_pkg::OP_SAR:    alu_r = W'($signed(v1_q) >>> v2_q[5:0]);
      smc_pkg::OP_AND:    alu_r = W'((v1_q != '0) && (v2_q != '0));
      smc_pkg::OP_OR:     alu_r = W'((v1_q != '0) || (v2_q != '0));
      smc_pkg::OP_NOT:    alu_r = W'(v1_q == '0);
      smc_pkg::OP_EQ:     alu_r = W'(v1_q == v2_q);
      smc_pkg::OP_NE:     alu_r = W'(v1_q != v2_q);
      smc_pkg::OP_GT:     alu_r = W'($signed(v2_q) < $signed(v1_q));
      smc_pkg::OP_LT:     alu_r = W'($signed(v1_q) < $signed(v2_q));
      smc_pkg::OP_GTE:    alu_r = W'(!($signed(v1_q) < $signed(v2_q)));
      smc_pkg::OP_LTE:    alu_r = W'(!($signed(v2_q) < $signed(v1_q)));
      default:            alu_r = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    ip_d       = ip_q;
    sp_d       = sp_q;
    stopped_d  = stopped_q;
    status_d   = status_q;
    exit_d     = exit_q;
    top_d      = top_q;
    sh_d       = sh_q;
    v1_d       = v1_q;
    v2_d       = v2_q;
    op_d       = op_q;
    badop_d    = badop_q;
    bytemode_d = bytemode_q;
    addr_d     = addr_q;
    cnt_d      = cnt_q;
    err        = smc_pkg::ST_RUN;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = addr_q + smc_pkg::MEM_AW'(cnt_q);
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_raddr  = sp_m1[smc_pkg::STK_AW-1:0];
    mdu_req    = '{start: 1'b0, op: smc_pkg::MDU_MUL};

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_RESP;
          if (!req_i.req_type) begin
            if (32'(req_i.load_addr) < 32'(smc_pkg::MEM_BYTES)) begin
              mem_we    = 1'b1;
              mem_waddr = smc_pkg::MEM_AW'(req_i.load_addr);
              mem_wdata = req_i.load_byte;
            end
          end else if (!stopped_q) begin
            if (ip_q > smc_pkg::IP_W'(smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES)) begin
              status_d  = smc_pkg::ST_BADADDR;
              stopped_d = 1'b1;
            end else begin
              addr_d  = ip_q[smc_pkg::MEM_AW-1:0];
              cnt_d   = '0;
              state_d = S_FETCH;
            end
          end
        end
      end

      S_FETCH: begin
        // byte k is requested at count k and arrives one count later
        if (cnt_q != '0) begin
          sh_d = {mem_rdata_q, sh_q[W-1:8]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == smc_pkg::BC_W'(smc_pkg::WORD_BYTES)) begin
          ip_d    = ip_q + smc_pkg::IP_W'(smc_pkg::WORD_BYTES);
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        op_d    = sh_q[6:1];
        badop_d = (|sh_q[W-1:7]) || (sh_q[6:1] > smc_pkg::OP_JMPZ);
        state_d = S_RD1;
      end

      S_RD1: begin
        v1_d      = stk_rdata_q;
        stk_raddr = sp_m2[smc_pkg::STK_AW-1:0];
        state_d   = S_RD2;
      end

      S_RD2: begin
        v2_d    = stk_rdata_q;
        state_d = S_EXEC;
      end

      S_EXEC: begin
        state_d = S_TOP0;
        if (!sh_q[0]) begin
          if (32'(sp_q) >= smc_pkg::STACK_DEPTH) begin
            err = smc_pkg::ST_OVER;
          end else begin
            stk_we    = 1'b1;
            stk_waddr = sp_q[smc_pkg::STK_AW-1:0];
            stk_wdata = W'($signed(sh_q) >>> 1);
            sp_d      = sp_q + 1'b1;
          end
        end else if (badop_q) begin
          err = smc_pkg::ST_BADOP;
        end else begin
          case (op_q) inside
            smc_pkg::OP_DUP: begin
              if (sp_q == '0) begin
                err = smc_pkg::ST_UNDER;
              end else if (32'(sp_q) >= smc_pkg::STACK_DEPTH) begin
                err = smc_pkg::ST_OVER;
              end else begin
                stk_we    = 1'b1;
                stk_waddr = sp_q[smc_pkg::STK_AW-1:0];
                stk_wdata = v1_q;
                sp_d      = sp_q + 1'b1;
              end
            end
            smc_pkg::OP_LOAD, smc_pkg::OP_LOADBYTE, smc_pkg::OP_EXIT,
            smc_pkg::OP_NEGATE, smc_pkg::OP_POP, smc_pkg::OP_BNOT,
            smc_pkg::OP_NOT, smc_pkg::OP_JMP: begin
              if (sp_q == '0) begin
                err = smc_pkg::ST_UNDER;
              end else begin
                case (op_q) inside
                  smc_pkg::OP_LOAD, smc_pkg::OP_LOADBYTE: begin
                    bytemode_d = (op_q == smc_pkg::OP_LOADBYTE);
                    if ((op_q == smc_pkg::OP_LOAD) ? !v1_word_ok : !v1_byte_ok) begin
                      err = smc_pkg::ST_BADADDR;
                    end else begin
                      addr_d  = v1_q[smc_pkg::MEM_AW-1:0];
                      cnt_d   = '0;
                      state_d = S_MEMRD;
                    end
                  end
                  smc_pkg::OP_EXIT: begin
                    exit_d = v1_q;
                    err    = smc_pkg::ST_EXIT;
                  end
                  smc_pkg::OP_POP: begin
                    sp_d = sp_m1;
                  end
                  smc_pkg::OP_JMP: begin
                    if (!v1_word_ok) begin
                      err = smc_pkg::ST_BADADDR;
                    end else begin
                      ip_d = v1_q[smc_pkg::IP_W-1:0];
                      sp_d = sp_m1;
                    end
                  end
                  default: begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_m1[smc_pkg::STK_AW-1:0];
                    stk_wdata = alu_r;
                  end
                endcase
              end
            end
            default: begin
              if (sp_q < smc_pkg::SP_W'(2)) begin
                err = smc_pkg::ST_UNDER;
              end else begin
                case (op_q) inside
                  smc_pkg::OP_STORE: begin
                    if (!v2_word_ok) begin
                      err = smc_pkg::ST_BADADDR;
                    end else begin
                      addr_d  = v2_q[smc_pkg::MEM_AW-1:0];
                      sh_d    = v1_q;
                      cnt_d   = '0;
                      state_d = S_MEMWR;
                    end
                  end
                  smc_pkg::OP_STOREBYTE: begin
                    if (!v2_byte_ok) begin
                      err = smc_pkg::ST_BADADDR;
                    end else begin
                      mem_we    = 1'b1;
                      mem_waddr = v2_q[smc_pkg::MEM_AW-1:0];
                      mem_wdata = v1_q[7:0];
                      sp_d      = sp_m2;
                    end
                  end
                  smc_pkg::OP_SWAP: begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_m1[smc_pkg::STK_AW-1:0];
                    stk_wdata = v2_q;
                    state_d   = S_SWAP2;
                  end
                  smc_pkg::OP_JMPZ: begin
                    // taken on a nonzero top
                    if ((v1_q != '0) && !v2_word_ok) begin
                      err = smc_pkg::ST_BADADDR;
                    end else begin
                      if (v1_q != '0) begin
                        ip_d = v2_q[smc_pkg::IP_W-1:0];
                      end
                      sp_d = sp_m2;
                    end
                  end
                  smc_pkg::OP_MUL, smc_pkg::OP_DIV, smc_pkg::OP_MOD: begin
                    if ((op_q != smc_pkg::OP_MUL) && (v2_q == '0)) begin
                      err = smc_pkg::ST_DIVZ;
                    end else begin
                      mdu_req.start = 1'b1;
                      mdu_req.op    = (op_q == smc_pkg::OP_MUL) ? smc_pkg::MDU_MUL :
                                      (op_q == smc_pkg::OP_DIV) ? smc_pkg::MDU_DIV :
                                                                  smc_pkg::MDU_REM;
                      state_d = S_MDU;
                    end
                  end
                  default: begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_m2[smc_pkg::STK_AW-1:0];
                    stk_wdata = alu_r;
                    sp_d      = sp_m1;
                  end
                endcase
              end
            end
          endcase
        end
        if (err != smc_pkg::ST_RUN) begin
          status_d  = err;
          stopped_d = 1'b1;
          state_d   = S_RESP;
        end
      end

      S_MEMRD: begin
        cnt_d = cnt_q + 1'b1;
        if (bytemode_q) begin
          if (cnt_q != '0) begin
            stk_we    = 1'b1;
            stk_waddr = sp_m1[smc_pkg::STK_AW-1:0];
            stk_wdata = W'($signed(mem_rdata_q));
            state_d   = S_TOP0;
          end
        end else begin
          if (cnt_q != '0) begin
            sh_d = {mem_rdata_q, sh_q[W-1:8]};
          end
          if (cnt_q == smc_pkg::BC_W'(smc_pkg::WORD_BYTES)) begin
            stk_we    = 1'b1;
            stk_waddr = sp_m1[smc_pkg::STK_AW-1:0];
            stk_wdata = {mem_rdata_q, sh_q[W-1:8]};
            state_d   = S_TOP0;
          end
        end
      end

      S_MEMWR: begin
        // little-endian, low byte first
        mem_we    = 1'b1;
        mem_waddr = addr_q + smc_pkg::MEM_AW'(cnt_q);
        mem_wdata = sh_q[7:0];
        sh_d      = {8'd0, sh_q[W-1:8]};
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == smc_pkg::BC_W'(smc_pkg::WORD_BYTES - 1)) begin
          sp_d    = sp_m2;
          state_d = S_TOP0;
        end
      end

      S_MDU: begin
        if (mdu_done) begin
          stk_we    = 1'b1;
          stk_waddr = sp_m2[smc_pkg::STK_AW-1:0];
          stk_wdata = mdu_res;
          sp_d      = sp_m1;
          state_d   = S_TOP0;
        end
      end

      S_SWAP2: begin
        stk_we    = 1'b1;
        stk_waddr = sp_m2[smc_pkg::STK_AW-1:0];
        stk_wdata = v1_q;
        state_d   = S_TOP0;
      end

      S_TOP0: begin
        state_d = S_TOP1;
      end

      S_TOP1: begin
        top_d   = stk_rdata_q;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ip_q      <= '0;
      sp_q      <= '0;
      stopped_q <= 1'b0;
      status_q  <= smc_pkg::ST_RUN;
      exit_q    <= '0;
      badop_q   <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      ip_q      <= ip_d;
      sp_q      <= sp_d;
      stopped_q <= stopped_d;
      status_q  <= status_d;
      exit_q    <= exit_d;
      badop_q   <= badop_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    sh_q       <= sh_d;
    v1_q       <= v1_d;
    v2_q       <= v2_d;
    op_q       <= op_d;
    bytemode_q <= bytemode_d;
    addr_q     <= addr_d;
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = (state_q == S_RESP);
  assign rsp_o.status      = status_q;
  assign rsp_o.next_ip     = ip_q[11:0];
  assign rsp_o.top_value   = (sp_q == '0) ? '0 : top_q;
  assign rsp_o.stack_count = sp_q;
  assign rsp_o.exit_code   = (status_q == smc_pkg::ST_EXIT) ? exit_q : '0;

  `SMC_ASSERT_IMP(a_sp_range, 1'b1, 32'(sp_q) <= smc_pkg::STACK_DEPTH, "stack count past depth")
  `SMC_ASSERT_IMP(a_rdy_vs_rsp, rsp_o.valid, !req_i.ready, "item taken while result pending")
  `SMC_ASSERT_IMP(a_mdu_done, mdu_done, state_q == S_MDU, "mul/div result outside its wait state")
  `SMC_ASSERT_NXT(a_stopped_hold, (state_q == S_IDLE) && req_i.valid && stopped_q,
                  $stable(ip_q) && $stable(sp_q) && $stable(status_q), "stopped machine changed")

endmodule

### test/smc_checker.sv
// checker of the stack machine core: watches both item channels, predicts each result
// and compares it field by field; depends on smc_pkg and the channel interfaces
module smc_checker (
  input  logic clk_i,
  input  logic rst_ni,
  smc_req_if   req_mon,
  smc_rsp_if   rsp_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]               status;
    logic [11:0]              ip;
    logic [63:0]              top;
    logic [smc_pkg::SP_W-1:0] cnt;
    logic [63:0]              code;
  } machine_view_t;

  machine_view_t view_q[$];

  logic [7:0]  mem_img [smc_pkg::MEM_BYTES];
  logic [63:0] stk_img [smc_pkg::STACK_DEPTH];
  int          sp_m;
  int          ip_m;
  bit          halted;
  logic [2:0]  held_status;
  logic [63:0] held_exit;

  function automatic logic [63:0] word_at(int a);
    logic [63:0] v;
    v = '0;
    for (int i = smc_pkg::WORD_BYTES - 1; i >= 0; i--) v = {v[55:0], mem_img[a + i]};
    return v;
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [2:0] run_word(logic [63:0] w);
    logic [5:0]  op;
    logic [63:0] v1, v2, r, q, m;
    if (!w[0]) begin
      if (sp_m >= smc_pkg::STACK_DEPTH) return smc_pkg::ST_OVER;
      stk_img[sp_m] = $signed(w) >>> 1;
      sp_m++;
      return smc_pkg::ST_RUN;
    end
    if (w[63:1] > 63'd32) return smc_pkg::ST_BADOP;
    op = w[6:1];
    if (op == smc_pkg::OP_DUP) begin
      if (sp_m < 1) return smc_pkg::ST_UNDER;
      if (sp_m >= smc_pkg::STACK_DEPTH) return smc_pkg::ST_OVER;
      stk_img[sp_m] = stk_img[sp_m - 1];
      sp_m++;
      return smc_pkg::ST_RUN;
    end
    if (op inside {smc_pkg::OP_LOAD, smc_pkg::OP_LOADBYTE, smc_pkg::OP_EXIT,
                   smc_pkg::OP_NEGATE, smc_pkg::OP_POP, smc_pkg::OP_BNOT,
                   smc_pkg::OP_NOT, smc_pkg::OP_JMP}) begin
      if (sp_m < 1) return smc_pkg::ST_UNDER;
      v1 = stk_img[sp_m - 1];
      case (op)
        smc_pkg::OP_LOAD: begin
          if (v1 > smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES) return smc_pkg::ST_BADADDR;
          r = word_at(int'(v1));
        end
        smc_pkg::OP_LOADBYTE: begin
          if (v1 >= smc_pkg::MEM_BYTES) return smc_pkg::ST_BADADDR;
          r = {{56{mem_img[v1][7]}}, mem_img[v1]};
        end
        smc_pkg::OP_EXIT: begin
          held_exit = v1;
          return smc_pkg::ST_EXIT;
        end
        smc_pkg::OP_NEGATE: r = -v1;
        smc_pkg::OP_POP: begin
          sp_m--;
          return smc_pkg::ST_RUN;
        end
        smc_pkg::OP_BNOT: r = ~v1;
        smc_pkg::OP_NOT: r = (v1 == 0);
        default: begin
          if (v1 > smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES) return smc_pkg::ST_BADADDR;
          ip_m = int'(v1);
          sp_m--;
          return smc_pkg::ST_RUN;
        end
      endcase
      stk_img[sp_m - 1] = r;
      return smc_pkg::ST_RUN;
    end
    if (sp_m < 2) return smc_pkg::ST_UNDER;
    v1 = stk_img[sp_m - 1];
    v2 = stk_img[sp_m - 2];
    case (op) inside
      smc_pkg::OP_STORE: begin
        if (v2 > smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES) return smc_pkg::ST_BADADDR;
        for (int i = 0; i < smc_pkg::WORD_BYTES; i++) mem_img[int'(v2) + i] = v1[8*i +: 8];
        sp_m -= 2;
        return smc_pkg::ST_RUN;
      end
      smc_pkg::OP_STOREBYTE: begin
        if (v2 >= smc_pkg::MEM_BYTES) return smc_pkg::ST_BADADDR;
        mem_img[v2] = v1[7:0];
        sp_m -= 2;
        return smc_pkg::ST_RUN;
      end
      smc_pkg::OP_SWAP: begin
        stk_img[sp_m - 1] = v2;
        stk_img[sp_m - 2] = v1;
        return smc_pkg::ST_RUN;
      end
      smc_pkg::OP_JMPZ: begin
        // taken on a nonzero top
        if (v1 != 0) begin
          if (v2 > smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES) return smc_pkg::ST_BADADDR;
          ip_m = int'(v2);
        end
        sp_m -= 2;
        return smc_pkg::ST_RUN;
      end
      smc_pkg::OP_ADD: r = v1 + v2;
      smc_pkg::OP_SUB: r = v1 - v2;
      smc_pkg::OP_MUL: r = v1 * v2;
      smc_pkg::OP_DIV, smc_pkg::OP_MOD: begin
        if (v2 == 0) return smc_pkg::ST_DIVZ;
        q = magnitude(v1) / magnitude(v2);
        m = magnitude(v1) % magnitude(v2);
        if (op == smc_pkg::OP_DIV) r = (v1[63] ^ v2[63]) ? -q : q;
        else r = v1[63] ? -m : m;
      end
      smc_pkg::OP_BAND: r = v1 & v2;
      smc_pkg::OP_BOR: r = v1 | v2;
      smc_pkg::OP_XOR: r = v1 ^ v2;
      smc_pkg::OP_SHR: r = v1 >> v2[5:0];
      smc_pkg::OP_SHL, smc_pkg::OP_SAL: r = v1 << v2[5:0];
      smc_pkg::OP_SAR: r = $signed(v1) >>> v2[5:0];
      smc_pkg::OP_AND: r = (v1 != 0 && v2 != 0);
      smc_pkg::OP_OR: r = (v1 != 0 || v2 != 0);
      smc_pkg::OP_EQ: r = (v1 == v2);
      smc_pkg::OP_NE: r = (v1 != v2);
      smc_pkg::OP_GT: r = $signed(v2) < $signed(v1);
      smc_pkg::OP_LT: r = $signed(v1) < $signed(v2);
      smc_pkg::OP_GTE: r = !($signed(v1) < $signed(v2));
      default: r = !($signed(v2) < $signed(v1));
    endcase
    stk_img[sp_m - 2] = r;
    sp_m--;
    return smc_pkg::ST_RUN;
  endfunction

  function automatic machine_view_t apply_item(logic rt, logic [11:0] a, logic [7:0] b);
    machine_view_t e;
    logic [2:0]    st;
    if (!rt) begin
      mem_img[a] = b;
    end else if (!halted) begin
      if (ip_m > smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES) begin
        st = smc_pkg::ST_BADADDR;
      end else begin
        ip_m += smc_pkg::WORD_BYTES;
        st = run_word(word_at(ip_m - smc_pkg::WORD_BYTES));
      end
      if (st != smc_pkg::ST_RUN) begin
        held_status = st;
        halted = 1'b1;
      end
    end
    e.status = held_status;
    e.ip     = ip_m[11:0];
    e.top    = sp_m > 0 ? stk_img[sp_m - 1] : '0;
    e.cnt    = sp_m[smc_pkg::SP_W-1:0];
    e.code   = held_status == smc_pkg::ST_EXIT ? held_exit : '0;
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    machine_view_t e;
    if (!rst_ni) begin
      sp_m        <= 0;
      ip_m        <= 0;
      halted      <= 1'b0;
      held_status <= smc_pkg::ST_RUN;
      held_exit   <= '0;
      fail_count  <= 0;
      pending     <= 0;
      view_q.delete();
    end else begin
      if (req_mon.valid && req_mon.ready)
        view_q.push_back(apply_item(req_mon.req_type, req_mon.load_addr, req_mon.load_byte));
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (view_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = view_q.pop_front();
          if (rsp_mon.status !== e.status ||
              rsp_mon.next_ip !== e.ip ||
              rsp_mon.top_value !== e.top ||
              rsp_mon.stack_count !== e.cnt ||
              rsp_mon.exit_code !== e.code)
            fail_count <= fail_count + 1;
          if (rsp_mon.status !== e.status)
            $error("status expected %0d actual %0d", e.status, rsp_mon.status);
          if (rsp_mon.next_ip !== e.ip)
            $error("next_ip expected %0d actual %0d", e.ip, rsp_mon.next_ip);
          if (rsp_mon.top_value !== e.top)
            $error("top_value expected %0h actual %0h", e.top, rsp_mon.top_value);
          if (rsp_mon.stack_count !== e.cnt)
            $error("stack_count expected %0d actual %0d", e.cnt, rsp_mon.stack_count);
          if (rsp_mon.exit_code !== e.code)
            $error("exit_code expected %0h actual %0h", e.code, rsp_mon.exit_code);
        end
      end
      pending <= view_q.size();
    end
  end
endmodule

### test/tb.sv
// top of the stack machine core bench: clock, reset, program stimulus and verdict
// depends on smc_pkg, the channel interfaces, stack_machine_core and smc_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   ip_t;
  int   sp_t;
  int   n_loads;
  int   n_steps;
  int   n_instr;
  bit   steady;
  int   word_sites[$];
  logic [2:0] last_status;

  logic [5:0] alu_ops [18] = '{smc_pkg::OP_ADD, smc_pkg::OP_SUB, smc_pkg::OP_MUL,
                               smc_pkg::OP_BAND, smc_pkg::OP_BOR, smc_pkg::OP_XOR,
                               smc_pkg::OP_SHR, smc_pkg::OP_SHL, smc_pkg::OP_SAR,
                               smc_pkg::OP_SAL, smc_pkg::OP_AND, smc_pkg::OP_OR,
                               smc_pkg::OP_EQ, smc_pkg::OP_NE, smc_pkg::OP_GT,
                               smc_pkg::OP_LT, smc_pkg::OP_GTE, smc_pkg::OP_LTE};
  logic [5:0] one_ops [3] = '{smc_pkg::OP_NEGATE, smc_pkg::OP_BNOT, smc_pkg::OP_NOT};

  smc_req_if req ();
  smc_rsp_if rsp ();

  stack_machine_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  smc_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req),
    .rsp_mon    (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp.ready <= steady || ($urandom_range(0, 99) >= 17);
  end

  task automatic send(input logic rt, input logic [11:0] a, input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 17) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.req_type  <= rt;
    req.load_addr <= a;
    req.load_byte <= b;
    do @(posedge clk_i); while (!req.ready);
    if (rt) n_steps++;
    else n_loads++;
  endtask

  task automatic put_word(input int a, input logic [63:0] w);
    for (int i = 0; i < smc_pkg::WORD_BYTES; i++) send(1'b0, 12'(a + i), w[8*i +: 8]);
  endtask

  // write the instruction at ip, then execute it
  task automatic exec_word(input logic [63:0] w);
    put_word(ip_t, w);
    word_sites.push_back(ip_t);
    send(1'b1, 12'($urandom), 8'($urandom));
    ip_t += smc_pkg::WORD_BYTES;
    n_instr++;
  endtask

  task automatic push(input logic [63:0] v);
    exec_word({v[62:0], 1'b0});
    sp_t++;
  endtask

  task automatic do_op(input logic [5:0] op, input int delta);
    exec_word({57'd0, op, 1'b1});
    sp_t += delta;
  endtask

  task automatic jump_to(input int t);
    push(64'(t));
    do_op(smc_pkg::OP_JMP, -1);
    ip_t = t;
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 20));
      1: return {x[62], x[62:0]};
      2: return $urandom_range(0, 1) ? 64'h3FFF_FFFF_FFFF_FFFF : 64'hC000_0000_0000_0000;
      default: return -64'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic int pick_site();
    return word_sites[$urandom_range(0, word_sites.size() - 1)];
  endfunction

  task automatic random_instr();
    logic [63:0] v;
    int          t;
    if (ip_t > 3960) begin
      jump_to($urandom_range(0, 3900));
      return;
    end
    if (sp_t > 56) begin
      do_op(smc_pkg::OP_POP, -1);
      return;
    end
    case ($urandom_range(0, 11))
      0, 1: push(pick_value());
      2: begin
        if (sp_t < 1) push(pick_value());
        else case ($urandom_range(0, 4))
          0: do_op(smc_pkg::OP_DUP, 1);
          1: do_op(smc_pkg::OP_POP, -1);
          default: do_op(one_ops[$urandom_range(0, 2)], 0);
        endcase
      end
      3, 4, 5: begin
        if (sp_t < 2) push(pick_value());
        else do_op(alu_ops[$urandom_range(0, 17)], -1);
      end
      6: begin
        do v = pick_value(); while (v == 0);
        push(v);
        push(pick_value());
        do_op($urandom_range(0, 1) ? smc_pkg::OP_DIV : smc_pkg::OP_MOD, -1);
      end
      7: begin
        if ($urandom_range(0, 1)) begin
          push(64'(pick_site()));
          do_op(smc_pkg::OP_LOAD, 0);
        end else begin
          push(64'(pick_site() + $urandom_range(0, 7)));
          do_op(smc_pkg::OP_LOADBYTE, 0);
        end
      end
      8: begin
        t = $urandom_range(0, smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES);
        push(64'(t));
        push(pick_value());
        if ($urandom_range(0, 1)) begin
          do_op(smc_pkg::OP_STORE, -2);
          word_sites.push_back(t);
        end else begin
          do_op(smc_pkg::OP_STOREBYTE, -2);
        end
      end
      9: begin
        if (sp_t < 2) push(pick_value());
        else do_op(smc_pkg::OP_SWAP, 0);
      end
      // leave room for the two words of a jump away
      10: jump_to($urandom_range(0, smc_pkg::MEM_BYTES - 2 * smc_pkg::WORD_BYTES));
      default: begin
        t = $urandom_range(0, 3900);
        push(64'(t));
        v = $urandom_range(0, 1) ? 64'd0 : pick_value() | 64'd1;
        push(v);
        do_op(smc_pkg::OP_JMPZ, -2);
        if (v != 0) ip_t = t;
      end
    endcase
  endtask

  // the machine halts for good on exit or any error, so exactly one ends the program
  task automatic finish_program();
    // move to low memory so that every ending fits
    jump_to(smc_pkg::WORD_BYTES);
    case ($urandom_range(0, 5))
      0: begin
        push(pick_value());
        do_op(smc_pkg::OP_EXIT, 0);
        last_status = smc_pkg::ST_EXIT;
      end
      1: begin
        while (sp_t > 0) do_op(smc_pkg::OP_POP, -1);
        do_op(smc_pkg::OP_POP, -1);
        last_status = smc_pkg::ST_UNDER;
      end
      2: begin
        jump_to(0);
        while (sp_t <= smc_pkg::STACK_DEPTH) push(pick_value());
        last_status = smc_pkg::ST_OVER;
      end
      3: begin
        push(64'd0);
        push(pick_value());
        do_op(smc_pkg::OP_DIV, -1);
        last_status = smc_pkg::ST_DIVZ;
      end
      4: begin
        exec_word({63'($urandom_range(33, 1000)) | (63'($urandom_range(0, 1)) << 40),
                   1'b1});
        last_status = smc_pkg::ST_BADOP;
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          push(64'd5000);
          do_op(smc_pkg::OP_JMP, 0);
        end else begin
          // fetch one past the last word
          jump_to(smc_pkg::MEM_BYTES - smc_pkg::WORD_BYTES);
          push(pick_value());
          send(1'b1, 12'($urandom), 8'($urandom));
        end
        last_status = smc_pkg::ST_BADADDR;
      end
    endcase
    repeat (3) send(1'b1, 12'($urandom), 8'($urandom));
    repeat (4) send(1'b0, 12'($urandom), 8'($urandom));
  endtask

  initial begin
    req.valid     = 1'b0;
    req.req_type  = 1'b0;
    req.load_addr = '0;
    req.load_byte = '0;
    rsp.ready     = 1'b0;
    steady        = 1'b0;
    ip_t          = 0;
    sp_t          = 0;
    n_loads       = 0;
    n_steps       = 0;
    n_instr       = 0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes: min from a shift, min / -1, min mod -1, full shifts
    push(64'h3FFF_FFFF_FFFF_FFFF);
    push(64'hC000_0000_0000_0000);
    do_op(smc_pkg::OP_SUB, -1);
    push(-64'd1);
    push(64'd1);
    push(64'hC000_0000_0000_0000);
    do_op(smc_pkg::OP_SHL, -1);
    do_op(smc_pkg::OP_DIV, -1);
    push(-64'd1);
    do_op(smc_pkg::OP_SWAP, 0);
    do_op(smc_pkg::OP_MOD, -1);
    push(64'd63);
    push(-64'd2);
    do_op(smc_pkg::OP_SAR, -1);
    jump_to(smc_pkg::MEM_BYTES - 2 * smc_pkg::WORD_BYTES);
    jump_to(8);

    while (n_loads + n_steps < 1300) begin
      steady = (n_instr >= 50 && n_instr < 80);
      random_instr();
    end
    steady = 1'b0;
    finish_program();
    req.valid <= 1'b0;

    while (pending != 0 || rsp.valid) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    $display("ran %0d instructions over %0d step and %0d byte write items",
             n_instr, n_steps, n_loads);
    $display("program ended with status code %0d", last_status);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb failed");
    $finish;
  end
endmodule
